// ===== hdl/sder_pkg.sv =====
// ----------------------------------------------------------------------------
// sder_pkg
// Shared constants and item types for the scanline depth edge rasterizer.
// ----------------------------------------------------------------------------
package sder_pkg;

  localparam int DefDepthLevels = 16;
  localparam int DefTableRows   = 32;
  localparam int DefScreenLines = 224;
  localparam int ClearBase      = -5;

  localparam logic [2:0] KIND_LOAD   = 3'd0;
  localparam logic [2:0] KIND_BEGIN  = 3'd1;
  localparam logic [2:0] KIND_DRAW   = 3'd2;
  localparam logic [2:0] KIND_FINISH = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;

  typedef struct packed {
    logic        [2:0]  kind;
    logic        [8:0]  index;
    logic        [11:0] table_value;
    logic signed [11:0] nearest_z;
    logic signed [11:0] farthest_z;
    logic signed [11:0] start_depth;
    logic signed [11:0] end_depth;
    logic signed [11:0] start_line;
    logic signed [11:0] end_line;
  } req_t;

  typedef struct packed {
    logic signed [12:0] line_value;
  } rsp_t;

  // Divider handshake between sequencer and shared divider.
  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

endpackage

// ===== hdl/sder_if.sv =====
// ----------------------------------------------------------------------------
// sder_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface sder_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/sder_div.sv =====
// ----------------------------------------------------------------------------
// sder_div
// Signed truncating divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sder_div
  import sder_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic        busy;
  logic        done;
  logic [5:0]  count;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [15:0] dmag;
  logic        neg;
  logic [32:0] trial;
  logic [31:0] rem_shift;

  assign rem_shift = {rem[30:0], quo[31]};
  assign trial     = {1'b0, rem_shift} - {17'd0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !req.start && (count == 6'd31);
      if (req.start) begin
        busy  <= 1'b1;
        count <= 6'd0;
        rem   <= '0;
        quo   <= req.num[31] ? 32'(-req.num) : req.num;
        dmag  <= req.den[15] ? 16'(-req.den) : req.den;
        neg   <= req.num[31] ^ req.den[15];
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[30:0], 1'b0};
        end
        count <= count + 6'd1;
        if (count == 6'd31) busy <= 1'b0;
      end
    end
  end

  assign rsp = {done, neg ? 32'(-quo) : quo};
endmodule

// ===== hdl/scanline_depth_edge_rasterizer.sv =====
// ----------------------------------------------------------------------------
// scanline_depth_edge_rasterizer
// Per-line depth and scroll-offset buffers fed by edges, sequenced over one
// shared divider.
// ----------------------------------------------------------------------------
//  channel  dir  payload  meaning
//  req      in   req_t    table load, begin, draw edge, finish, read line
//  rsp      out  rsp_t    shown scroll offset, one per read request
//
// A read passes through S_READ and S_RDWAIT. Begin and finish sweep all
// SCREEN_LINES lines unless the frame is skipped. Draw takes each visible
// line through S_LINE, S_DIV1, S_DIV2, S_TEST and S_WRITE, adding S_DIV3 and
// S_TAB if it passes the depth test: each quotient comes from the shared
// divider, two for depth and level, a third for the row. After reset a
// clearing pass over all SCREEN_LINES lines runs before the first request is
// taken. A read waits only while the result register still holds an unaccepted response.
module scanline_depth_edge_rasterizer
  import sder_pkg::*;
#(
  parameter int DEPTH_LEVELS = DefDepthLevels,
  parameter int TABLE_ROWS   = DefTableRows,
  parameter int SCREEN_LINES = DefScreenLines
) (
  input logic clk,
  input logic rst,
  sder_if.sink   req,
  sder_if.source rsp
);
  localparam int TableSize = DEPTH_LEVELS * TABLE_ROWS;
  localparam int TW = $clog2(TableSize);
  localparam int LW = $clog2(SCREEN_LINES);
  localparam int DW = $clog2(DEPTH_LEVELS);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_COPY    = 4'd2;
  localparam logic [3:0] S_LINE    = 4'd3;
  localparam logic [3:0] S_DIV1    = 4'd4;
  localparam logic [3:0] S_DIV2    = 4'd5;
  localparam logic [3:0] S_TEST    = 4'd6;
  localparam logic [3:0] S_DIV3    = 4'd7;
  localparam logic [3:0] S_TAB     = 4'd8;
  localparam logic [3:0] S_WRITE   = 4'd9;
  localparam logic [3:0] S_READ    = 4'd10;
  localparam logic [3:0] S_CLEAR_W = 4'd11;
  localparam logic [3:0] S_RDWAIT  = 4'd12;

  logic [3:0] state;

  logic [11:0]        scan_mem  [TableSize];
  logic [DW-1:0]      depth_mem [SCREEN_LINES];
  logic signed [13:0] work_mem  [SCREEN_LINES];
  logic signed [13:0] shown_mem [SCREEN_LINES];

  logic signed [11:0] near_limit;
  logic signed [11:0] far_limit;
  logic               frame_skipped;

  logic [LW:0]        line;       // sweep, draw or read line
  logic [LW:0]        hi;
  logic signed [12:0] span;
  logic signed [12:0] dy;
  logic signed [11:0] da;
  logic signed [12:0] ddep;
  logic signed [11:0] ay;
  logic [DW-1:0]      level;
  logic [DW-1:0]      old_level;
  logic [11:0]        tab_q;
  logic signed [13:0] work_q;
  logic signed [13:0] shown_q;
  logic signed [12:0] rsp_value;
  logic               rsp_valid;
  logic               rsp_load;

  logic               div_start;
  logic               div_start_next;
  logic signed [31:0] div_num;
  logic signed [15:0] div_den;

  div_req_t dreq;
  div_rsp_t drsp;

  assign dreq = {div_start, div_num, div_den};

  sder_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic signed [12:0] range_w;
  logic signed [31:0] lvl_w;
  logic signed [13:0] clear_val;
  logic signed [12:0] far_w;
  logic signed [12:0] sum_w;
  logic signed [12:0] ay_lo;
  logic [LW:0]        hi_w;

  assign range_w   = 13'(far_limit) - 13'(near_limit);
  assign lvl_w     = 32'(DEPTH_LEVELS - 1) - drsp.quo;
  assign clear_val = 14'(ClearBase) - 14'(signed'({1'b0, line}));
  assign sum_w     = 13'(req.data.nearest_z) + 13'(req.data.farthest_z);
  // round toward zero for odd negative sums
  assign far_w     = (sum_w + ((sum_w[12] & sum_w[0]) ? 13'sd1 : 13'sd0)) >>> 1;
  assign ay_lo     = req.data.start_line[11] ? 13'sd0 : 13'(req.data.start_line);
  assign hi_w      = (req.data.end_line > 12'(SCREEN_LINES - 1))
                     ? (LW + 1)'(SCREEN_LINES - 1) : (LW + 1)'(req.data.end_line);

  assign div_start_next = (state == S_LINE) || ((state == S_DIV1) && drsp.done) ||
                          ((state == S_TEST) && (level > old_level));

  assign rsp_load  = (state == S_RDWAIT) && (!rsp_valid || rsp.ready);

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data.line_value = rsp_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b0;
    end else begin
      div_start <= div_start_next;
    end
  end

  // one-entry result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_value <= (line < (LW + 1)'(SCREEN_LINES)) ? 13'(shown_q) : 13'sd0;
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      line          <= '0;
      near_limit    <= '0;
      far_limit     <= 12'sd1;
      frame_skipped <= 1'b1;
    end else begin
      unique case (state)
        S_CLEAR: begin
          depth_mem[line[LW-1:0]] <= '0;
          work_mem[line[LW-1:0]]  <= clear_val;
          shown_mem[line[LW-1:0]] <= clear_val;
          line <= line + 1'b1;
          if (line == (LW + 1)'(SCREEN_LINES - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid) begin
            unique case (req.data.kind)
              KIND_LOAD: begin
                if (32'(req.data.index) < TableSize)
                  scan_mem[req.data.index[TW-1:0]] <= req.data.table_value;
              end
              KIND_BEGIN: begin
                near_limit <= req.data.nearest_z;
                far_limit  <= 12'(far_w + 13'sd1);
                if (req.data.nearest_z == req.data.farthest_z ||
                    far_w + 13'sd1 == 13'(req.data.nearest_z)) begin
                  frame_skipped <= 1'b1;
                end else begin
                  frame_skipped <= 1'b0;
                  line  <= '0;
                  state <= S_CLEAR_W;
                end
              end
              KIND_DRAW: begin
                if (!frame_skipped && req.data.start_line < req.data.end_line
                    && !req.data.end_line[11]
                    && ay_lo < 13'(SCREEN_LINES)) begin
                  line  <= (LW + 1)'(ay_lo);
                  hi    <= hi_w;
                  ay    <= req.data.start_line;
                  da    <= req.data.start_depth;
                  ddep  <= 13'(req.data.end_depth) - 13'(req.data.start_depth);
                  span  <= 13'(req.data.end_line) - 13'(req.data.start_line);
                  state <= S_LINE;
                end
              end
              KIND_FINISH: begin
                if (!frame_skipped) begin
                  line  <= '0;
                  state <= S_COPY;
                end
              end
              KIND_READ: begin
                line  <= (LW + 1)'(req.data.index);
                state <= S_READ;
              end
              default: ;
            endcase
          end
        end
        S_CLEAR_W: begin
          depth_mem[line[LW-1:0]] <= '0;
          work_mem[line[LW-1:0]]  <= clear_val;
          line <= line + 1'b1;
          if (line == (LW + 1)'(SCREEN_LINES - 1)) state <= S_IDLE;
        end
        S_COPY: begin
          shown_mem[line[LW-1:0]] <= work_q;
          line <= line + 1'b1;
          if (line == (LW + 1)'(SCREEN_LINES - 1)) state <= S_IDLE;
        end
        S_LINE: begin
          dy      <= 13'(signed'({1'b0, line})) - 13'(ay);
          div_num <= 32'(ddep) * 32'(13'(signed'({1'b0, line})) - 13'(ay));
          div_den <= 16'(span);
          state   <= S_DIV1;
        end
        S_DIV1: if (drsp.done) begin
          div_num <= (32'(da) + drsp.quo - 32'(near_limit)) * 32'(DEPTH_LEVELS - 1);
          div_den <= 16'(range_w);
          state   <= S_DIV2;
        end
        S_DIV2: if (drsp.done) begin
          level <= lvl_w[31] ? '0 :
                   (lvl_w > 32'(DEPTH_LEVELS - 1)) ? DW'(DEPTH_LEVELS - 1) : DW'(lvl_w);
          old_level <= depth_mem[line[LW-1:0]];
          state <= S_TEST;
        end
        S_TEST: begin
          if (level > old_level) begin
            div_num <= 32'(dy) * 32'(TABLE_ROWS - 1);
            div_den <= 16'(span);
            state   <= S_DIV3;
          end else begin
            state <= S_WRITE;
          end
        end
        S_DIV3: if (drsp.done) begin
          tab_q <= scan_mem[TW'(32'(level) * TABLE_ROWS + drsp.quo)];
          state <= S_TAB;
        end
        S_TAB: begin
          depth_mem[line[LW-1:0]] <= level;
          work_mem[line[LW-1:0]]  <= 14'(tab_q) - 14'(signed'({1'b0, line}));
          state <= S_WRITE;
        end
        S_WRITE: begin
          line <= line + 1'b1;
          state <= (line == hi) ? S_IDLE : S_LINE;
        end
        S_READ: state <= S_RDWAIT;
        S_RDWAIT: if (rsp_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Registered buffer reads; copy sweep leads writes by one line.
  logic [LW-1:0] rd_addr;
  always_comb begin
    rd_addr = line[LW-1:0];
    if (state == S_IDLE && req.valid && req.data.kind == KIND_FINISH) rd_addr = '0;
    else if (state == S_COPY) rd_addr = LW'(line + 1'b1);
  end
  always_ff @(posedge clk) begin
    work_q  <= work_mem[rd_addr];
    shown_q <= shown_mem[rd_addr];
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data.line_value))
    else $error("response dropped or changed while stalled");
  a_rsp_read: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_RDWAIT) else $error("stray response");
  a_skip_draw: assert property (@(posedge clk) disable iff (rst)
    frame_skipped |-> state != S_COPY) else $error("copy in skipped frame");
endmodule
